@@ src/mpq_pkg.sv @@
`timescale 1ns / 1ps
// Package for the min priority queue: field widths, operation and status codes,
// and the word types passed between the cells of the sorted chain.
// No dependencies.
package mpq_pkg;

  localparam int KEY_W       = 16;
  localparam int TAG_W       = 16;
  localparam int COUNT_OUT_W = 6;
  localparam int DEF_DEPTH   = 32;

  // Operation carried in the mode field of an input word
  localparam logic MODE_INSERT  = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // One queue entry as held by a cell
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic             ins;
    logic             ext;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } cell_ctl_t;

endpackage

@@ src/mpq_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the min priority queue input and result words.
// Depends on mpq_pkg.
interface mpq_in_if import mpq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [KEY_W-1:0] key_in;
  logic [TAG_W-1:0] tag_in;

  modport source (output valid, output mode, output key_in, output tag_in, input ready);
  modport sink   (input valid, input mode, input key_in, input tag_in, output ready);
endinterface

interface mpq_out_if import mpq_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   taken_valid;
  logic [TAG_W-1:0]       taken_tag;
  logic [KEY_W-1:0]       taken_key;
  logic [1:0]             status;
  logic [KEY_W-1:0]       head_key;
  logic [TAG_W-1:0]       head_tag;
  logic [COUNT_OUT_W-1:0] entry_count;
  logic                   is_empty;

  modport source (output valid, output taken_valid, output taken_tag, output taken_key,
                  output status, output head_key, output head_tag, output entry_count,
                  output is_empty, input ready);
  modport sink   (input valid, input taken_valid, input taken_tag, input taken_key,
                  input status, input head_key, input head_tag, input entry_count,
                  input is_empty, output ready);
endinterface

@@ src/mpq_cell.sv @@
`timescale 1ns / 1ps
// One cell of the sorted chain: holds one entry, compares it with the broadcast key
// and takes its own, its left or right neighbor's, or the new entry. Depends on mpq_pkg.
module mpq_cell import mpq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl_i,
  input  entry_t    left_i,
  input  logic      left_gt_i,
  input  entry_t    right_i,
  output entry_t    ent_o,
  output logic      gt_o
);

  logic             valid_r, valid_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [TAG_W-1:0] tag_r, tag_nxt;

  // New entry goes behind every held entry with an equal or smaller key
  assign gt_o = !valid_r || (key_r > ctl_i.key);

  // Next entry: shift toward head on extract, open a gap on insert
  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    tag_nxt   = tag_r;
    if (ctl_i.ext) begin
      valid_nxt = right_i.valid;
      key_nxt   = right_i.key;
      tag_nxt   = right_i.tag;
    end else if (ctl_i.ins && gt_o) begin
      if (left_gt_i) begin
        valid_nxt = left_i.valid;
        key_nxt   = left_i.key;
        tag_nxt   = left_i.tag;
      end else begin
        valid_nxt = 1'b1;
        key_nxt   = ctl_i.key;
        tag_nxt   = ctl_i.tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    tag_r <= tag_nxt;
  end

  assign ent_o = '{valid: valid_r, key: key_r, tag: tag_r};

endmodule

@@ src/min_priority_queue.sv @@
`timescale 1ns / 1ps
// Top level of the min priority queue: a chain of QUEUE_DEPTH sorting cells and a result register.
// Depends on mpq_pkg, mpq_if (mpq_in_if, mpq_out_if) and mpq_cell.

// Entries are kept sorted in a row of QUEUE_DEPTH cells, smallest key at the head and
// equal keys in arrival order. Every cell compares its entry with the incoming key in
// the same cycle, so an insert or an extract is applied to the whole chain at once: one
// word is accepted per cycle as long as the result word is taken, and the result is
// registered on acceptance. A held result stalls the input. The head fields, entry count
// and empty flag of the result reflect the queue after that word. No clearing pass is
// needed after reset.
module min_priority_queue import mpq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  mpq_in_if.sink   in_ch,
  mpq_out_if.source out_ch
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  logic             taken_valid_r;
  logic [TAG_W-1:0] taken_tag_r;
  logic [KEY_W-1:0] taken_key_r;
  status_t          status_r;

  logic      accept;
  logic      is_full, is_empt;
  cell_ctl_t ctl;
  entry_t    cell_ent [QUEUE_DEPTH];
  logic      cell_gt  [QUEUE_DEPTH];
  logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

  // Handshake: a new word enters when the result slot is free or being drained
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign is_full = (count_r == CNT_W'(QUEUE_DEPTH));
  assign is_empt = (count_r == '0);

  // Broadcast control to the cells
  assign ctl.ins = accept && (in_ch.mode == MODE_INSERT) && !is_full;
  assign ctl.ext = accept && (in_ch.mode == MODE_EXTRACT) && !is_empt;
  assign ctl.key = in_ch.key_in;
  assign ctl.tag = in_ch.tag_in;

  // Sorted cell chain
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_ent, right_ent;
    logic   left_gt;
    if (i == 0) begin : g_first
      assign left_ent = '0;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_ent = cell_ent[i-1];
      assign left_gt  = cell_gt[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_ent = '0;
    end else begin : g_inner
      assign right_ent = cell_ent[i+1];
    end
    mpq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl_i     (ctl),
      .left_i    (left_ent),
      .left_gt_i (left_gt),
      .right_i   (right_ent),
      .ent_o     (cell_ent[i]),
      .gt_o      (cell_gt[i])
    );
  end

  // Entry count
  always_comb begin
    count_nxt = count_r;
    if (ctl.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.ext) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register: extracted entry and status
  always_ff @(posedge clk) begin
    if (accept) begin
      taken_valid_r <= ctl.ext;
      taken_key_r   <= ctl.ext ? cell_ent[0].key : '0;
      taken_tag_r   <= ctl.ext ? cell_ent[0].tag : '0;
      case (in_ch.mode)
        MODE_INSERT:  status_r <= is_full ? ST_FULL : ST_OK;
        MODE_EXTRACT: status_r <= is_empt ? ST_EMPTY : ST_OK;
        default:      status_r <= ST_OK;
      endcase
    end
  end

  // Head and count come straight from the state, which holds while a result waits
  assign count_ext          = {{COUNT_OUT_W{1'b0}}, count_r};
  assign out_ch.valid       = out_valid_r;
  assign out_ch.taken_valid = taken_valid_r;
  assign out_ch.taken_tag   = taken_tag_r;
  assign out_ch.taken_key   = taken_key_r;
  assign out_ch.status      = status_r;
  assign out_ch.head_key    = cell_ent[0].valid ? cell_ent[0].key : '0;
  assign out_ch.head_tag    = cell_ent[0].valid ? cell_ent[0].tag : '0;
  assign out_ch.entry_count = count_ext[COUNT_OUT_W-1:0];
  assign out_ch.is_empty    = is_empt;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for min_priority_queue: directed and random insert/extract words
// with random idling on both channels, checked against a behavioral queue model.
// Depends on mpq_pkg, mpq_if and the min_priority_queue RTL.
module tb;
  import mpq_pkg::*;

  localparam int DEPTH       = 32;
  localparam int WORD_TARGET = 1950;
  localparam int QUIET_FROM  = 1700;

  typedef struct packed {
    logic             mode;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } queue_word_t;

  typedef struct packed {
    logic                   taken_valid;
    logic [TAG_W-1:0]       taken_tag;
    logic [KEY_W-1:0]       taken_key;
    status_t                status;
    logic [KEY_W-1:0]       head_key;
    logic [TAG_W-1:0]       head_tag;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic                   is_empty;
  } queue_result_t;

  logic clk;
  logic rst_n;

  mpq_in_if  in_ch ();
  mpq_out_if out_ch ();

  min_priority_queue #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Model state: entries in arrival order
  logic [KEY_W-1:0] held_keys[$];
  logic [TAG_W-1:0] held_tags[$];

  queue_word_t   words_to_send[$];
  queue_result_t due_results[$];

  int  queued_total   = 0;
  int  accepted_words = 0;
  int  results_seen   = 0;
  int  errors         = 0;
  bit  in_taken       = 1'b0;
  int  send_gap       = 0;
  int  recv_gap       = 0;
  int  hold_left      = 0;
  bit  long_hold_done = 1'b0;

  wire quiet = (accepted_words >= QUIET_FROM);

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Earliest arrival among the smallest keys
  function automatic int min_slot();
    int best;
    best = 0;
    for (int i = 1; i < held_keys.size(); i++)
      if (held_keys[i] < held_keys[best]) best = i;
    return best;
  endfunction

  // Apply one word to the model and return the result it should produce
  function automatic queue_result_t apply_queue_op(input queue_word_t w);
    queue_result_t r;
    int pos;
    r = '0;
    r.status = ST_OK;
    if (w.mode == MODE_INSERT) begin
      if (held_keys.size() >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        held_keys = {held_keys, w.key};
        held_tags = {held_tags, w.tag};
      end
    end else begin
      if (held_keys.size() == 0) begin
        r.status = ST_EMPTY;
      end else begin
        pos = min_slot();
        r.taken_valid = 1'b1;
        r.taken_key   = held_keys[pos];
        r.taken_tag   = held_tags[pos];
        held_keys.delete(pos);
        held_tags.delete(pos);
      end
    end
    if (held_keys.size() != 0) begin
      pos = min_slot();
      r.head_key = held_keys[pos];
      r.head_tag = held_tags[pos];
    end
    r.entry_count = COUNT_OUT_W'(held_keys.size());
    r.is_empty    = (held_keys.size() == 0);
    return r;
  endfunction

  task automatic note_field(input string name, input logic [15:0] want, input logic [15:0] got,
                            inout bit bad);
    if (want !== got) begin
      if (errors < 10)
        $display("%0t: result %0d field %s expected %h got %h", $realtime, results_seen,
                 name, want, got);
      bad = 1'b1;
    end
  endtask

  // Predict on input acceptance, check on result acceptance
  always @(posedge clk) begin : score
    queue_word_t   w;
    queue_result_t want;
    bit            bad;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        w.mode = in_ch.mode;
        w.key  = in_ch.key_in;
        w.tag  = in_ch.tag_in;
        due_results = {due_results, apply_queue_op(w)};
        accepted_words++;
      end
      if (out_ch.valid && out_ch.ready) begin
        bad = 1'b0;
        if (due_results.size() == 0) begin
          if (errors < 10)
            $display("%0t: result %0d arrived with nothing expected", $realtime, results_seen);
          bad = 1'b1;
        end else begin
          want = due_results.pop_front();
          note_field("taken_valid", want.taken_valid, out_ch.taken_valid, bad);
          note_field("taken_tag", want.taken_tag, out_ch.taken_tag, bad);
          note_field("taken_key", want.taken_key, out_ch.taken_key, bad);
          note_field("status", want.status, out_ch.status, bad);
          note_field("head_key", want.head_key, out_ch.head_key, bad);
          note_field("head_tag", want.head_tag, out_ch.head_tag, bad);
          note_field("entry_count", want.entry_count, out_ch.entry_count, bad);
          note_field("is_empty", want.is_empty, out_ch.is_empty, bad);
        end
        if (bad) errors++;
        results_seen++;
      end
    end
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
  end

  // Input driver: holds a word until taken, with random idle bursts
  always @(negedge clk) begin : drive_words
    queue_word_t w;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_taken) begin
      // word still waiting for ready
    end else if (send_gap > 0) begin
      in_ch.valid <= 1'b0;
      send_gap--;
    end else if (words_to_send.size() > 0 && !quiet && $urandom_range(0, 9) == 0) begin
      in_ch.valid <= 1'b0;
      send_gap = $urandom_range(0, 18);
    end else if (words_to_send.size() > 0) begin
      w = words_to_send.pop_front();
      in_ch.valid  <= 1'b1;
      in_ch.mode   <= w.mode;
      in_ch.key_in <= w.key;
      in_ch.tag_in <= w.tag;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Result receiver: random stalls plus one long hold while words are backed up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else if (!long_hold_done && results_seen >= 300 && words_to_send.size() > 40) begin
      out_ch.ready <= 1'b0;
      long_hold_done = 1'b1;
      hold_left = 90;
    end else if (recv_gap > 0) begin
      out_ch.ready <= 1'b0;
      recv_gap--;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_ch.ready <= 1'b0;
      recv_gap = $urandom_range(0, 18);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic add_word(input logic mode, input logic [KEY_W-1:0] key,
                          input logic [TAG_W-1:0] tag);
    queue_word_t w;
    w.mode = mode;
    w.key  = key;
    w.tag  = tag;
    words_to_send = {words_to_send, w};
    queued_total++;
  endtask

  // Sender pause: every queued word has produced its result
  task automatic wait_drained();
    while (results_seen != queued_total) @(negedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key(input int style);
    case (style)
      0: return KEY_W'($urandom);
      1: return KEY_W'($urandom_range(0, 7));
      default: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return '1;
          default: return KEY_W'($urandom);
        endcase
      end
    endcase
  endfunction

  // Stimulus
  initial begin : stimulus
    int kind;
    int len;
    int style;
    int ins_pct;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.mode   = MODE_INSERT;
    in_ch.key_in = '0;
    in_ch.tag_in = '0;
    out_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // Directed: empty extract, key/tag extremes, equal keys in arrival order
    add_word(MODE_EXTRACT, 16'h1234, 16'h5678);
    add_word(MODE_INSERT, 16'hFFFF, 16'h0000);
    add_word(MODE_INSERT, 16'h0000, 16'hFFFF);
    add_word(MODE_INSERT, 16'h8000, 16'h1234);
    add_word(MODE_INSERT, 16'h0000, 16'h0001);
    add_word(MODE_INSERT, 16'hFFFF, 16'hFFFF);
    repeat (5) add_word(MODE_EXTRACT, 16'hFFFF, 16'hFFFF);
    add_word(MODE_EXTRACT, 16'h0000, 16'h0000);
    add_word(MODE_INSERT, 16'h5555, 16'hAAAA);
    add_word(MODE_INSERT, 16'hAAAA, 16'h5555);
    add_word(MODE_INSERT, 16'h5555, 16'h0F0F);
    repeat (3) add_word(MODE_EXTRACT, 16'h0000, 16'h0000);
    add_word(MODE_EXTRACT, 16'hAAAA, 16'h5555);
    wait_drained();

    // Random phases: filling, draining and balanced mixes
    while (queued_total < WORD_TARGET) begin
      kind  = $urandom_range(0, 2);
      style = $urandom_range(0, 2);
      len   = $urandom_range(60, 200);
      case (kind)
        0: ins_pct = 85;
        1: ins_pct = 15;
        default: ins_pct = 50;
      endcase
      for (int i = 0; i < len && queued_total < WORD_TARGET; i++) begin
        if ($urandom_range(1, 100) <= ins_pct)
          add_word(MODE_INSERT, pick_key(style), TAG_W'($urandom));
        else
          add_word(MODE_EXTRACT, KEY_W'($urandom), TAG_W'($urandom));
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Run limit
  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
